>>> rtl/rational_fraction_alu_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational fraction ALU
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_FRACTION_ALU_TOP_ASSERT_SVH
`define RATIONAL_FRACTION_ALU_TOP_ASSERT_SVH

// implication checked every cycle out of reset
`define RFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the following cycle
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// Rational fraction ALU package
// Shared widths, codes and the word passed from front to back.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int Width = 32;
    localparam int MagW  = 2 * Width;
    localparam int CntW  = $clog2(MagW + 1);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] num_a;
        logic [31:0] den_a;
        logic [31:0] num_b;
        logic [31:0] den_b;
    } item_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [31:0] res_den;
        logic [1:0]  status;
    } result_t;

    localparam int QDepth = 2;

endpackage

>>> rtl/rational_fraction_alu_top.sv
// Work per word: a binary gcd and two 64-step restoring divisions by the gcd.
// Zero numerator or zero denominator words skip both.
// Throughput: one word at a time in the back end; the front queue holds two more.
// Reset: rst_n asynchronous active low; clears queue and result state.
// ----------------------------------------------------------------------------
// Rational fraction ALU top level
// Queue-style ports around the front queue and the reducing back end.
// ----------------------------------------------------------------------------
`include "rational_fraction_alu_top_assert.svh"

module rational_fraction_alu_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic signed [31:0] num_a,
    input  logic signed [31:0] den_a,
    input  logic signed [31:0] num_b,
    input  logic signed [31:0] den_b,
    output logic        empty,
    input  logic        pop,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic [1:0]  status
);

    rfa_pkg::item_t   in_item;
    rfa_pkg::item_t   q_item;
    rfa_pkg::result_t res;
    logic             q_valid;
    logic             q_take;
    logic             err_word;
    logic             zero_data;

    assign in_item = '{action: action, num_a: num_a, den_a: den_a,
                       num_b: num_b, den_b: den_b};

    rfa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    rfa_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign res_num = res.res_num;
    assign res_den = res.res_den;
    assign status  = res.status;

    assign err_word  = !empty && (status != rfa_pkg::ST_OK);
    assign zero_data = (res_num == '0) && (res_den == '0);

    `RFA_ASSERT_IMP(a_status_code, !empty, status != rfa_pkg::ST_RSVD, "reserved status")
    `RFA_ASSERT_IMP(a_err_zero, err_word, zero_data, "error word carries data")
    `RFA_ASSERT_IMP(a_take_valid, q_take, q_valid, "back end took from empty queue")

endmodule

>>> rtl/rfa_front.sv
// ----------------------------------------------------------------------------
// Rational fraction ALU front end
// Accept words and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rfa_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  rfa_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_take,
    output rfa_pkg::item_t  q_item
);

    rfa_pkg::item_t slot_reg [rfa_pkg::QDepth];
    logic [1:0] cnt_reg;
    logic       wr_reg;
    logic       rd_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'(rfa_pkg::QDepth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= in_item;
    end

endmodule

>>> rtl/rfa_back.sv
// ----------------------------------------------------------------------------
// Rational fraction ALU back end
// Form the raw fraction, reduce it by binary gcd and restoring division.
// ----------------------------------------------------------------------------
module rfa_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_take,
    input  rfa_pkg::item_t   q_item,
    output logic             empty,
    input  logic             pop,
    output rfa_pkg::result_t res
);

    localparam int M = rfa_pkg::MagW;
    localparam int W = rfa_pkg::Width;
    localparam int C = rfa_pkg::CntW;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_FORM, S_GSTRIP, S_GLOOP, S_DIVN, S_DIVD,
        S_CHK, S_OUT
    } state_t;

    state_t        state_reg;
    logic [1:0]    act_reg;
    logic [W-1:0]  ma_reg, mb_reg, mc_reg, md_reg;
    logic          sa_reg, sb_reg, sc_reg, sd_reg;
    logic          same_reg;
    logic [M-1:0]  p0_reg, p1_reg;
    logic          s0_reg, s1_reg;
    logic [M:0]    nm_reg;
    logic          nneg_reg, dneg_reg;
    logic [M-1:0]  dm_reg;
    logic [M-1:0]  gu_reg, gv_reg;
    logic [C-1:0]  sh_reg;
    logic [M-1:0]  g_reg;
    logic [M-1:0]  quo_reg, rem_reg;
    logic [C-1:0]  bit_reg;
    logic [M-1:0]  qn_reg;
    rfa_pkg::result_t fin_reg;
    rfa_pkg::result_t out_reg;
    logic          full_reg;

    logic [W-1:0]  xa, xb, xc, xd;
    logic [M-1:0]  mul_x;
    logic [W-1:0]  mul_l, mul_r;
    logic [M:0]    sum_n;
    logic          sum_neg;
    logic [M-1:0]  rem_sh;
    logic [M:0]    rem_try;
    logic [M-1:0]  half;
    logic          is_addsub;
    logic          out_load;

    function automatic logic [W-1:0] mag_of(input logic [31:0] v);
        logic [W-1:0] t;
        t = v[W-1:0];
        mag_of = t[W-1] ? (~t + 1'b1) : t;
    endfunction

    always_comb
    begin
        xa = mag_of(q_item.num_a);
        xb = mag_of(q_item.den_a);
        xc = mag_of(q_item.num_b);
        xd = mag_of(q_item.den_b);
    end

    assign is_addsub = (act_reg == rfa_pkg::ACT_ADD) || (act_reg == rfa_pkg::ACT_SUB);

    always_comb
    begin
        mul_l = mb_reg;
        mul_r = md_reg;
        unique case (state_reg)
            S_MUL1:
            begin
                if (act_reg == rfa_pkg::ACT_DIV)
                    mul_r = mc_reg;
            end
            S_MUL2:
            begin
                mul_l = ma_reg;
                if (act_reg == rfa_pkg::ACT_MUL)
                    mul_r = mc_reg;
            end
            S_MUL3:
            begin
                mul_l = mc_reg;
                mul_r = mb_reg;
            end
            default: ;
        endcase
        mul_x = M'(mul_l) * M'(mul_r);
    end

    always_comb
    begin
        logic [M:0] a, b;
        logic an, bn;
        a = {1'b0, p0_reg};
        b = {1'b0, p1_reg};
        an = s0_reg && (p0_reg != '0);
        bn = s1_reg && (p1_reg != '0);
        if (act_reg == rfa_pkg::ACT_SUB)
            bn = !bn && (p1_reg != '0);
        if (an == bn)
        begin
            sum_n = a + b;
            sum_neg = an;
        end
        else if (a >= b)
        begin
            sum_n = a - b;
            sum_neg = an;
        end
        else
        begin
            sum_n = b - a;
            sum_neg = bn;
        end
        rem_sh  = {rem_reg[M-2:0], qn_reg[M-1]};
        rem_try = {1'b0, rem_sh} - {1'b0, g_reg};
        half    = M'(1) << (W - 1);
    end

    assign q_take   = (state_reg == S_IDLE) && q_valid;
    assign empty    = !full_reg;
    assign res      = out_reg;
    assign out_load = (state_reg == S_OUT) && (!full_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg  <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                full_reg <= 1'b1;
                out_reg  <= fin_reg;
            end
            else if (pop && full_reg)
                full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (q_valid)
                        state_reg <= S_MUL1;
                S_MUL1:   state_reg <= S_MUL2;
                S_MUL2:   state_reg <= S_MUL3;
                S_MUL3:   state_reg <= S_FORM;
                S_FORM:   state_reg <= S_GSTRIP;
                S_GSTRIP:
                    if (dm_reg == '0 || nm_reg == '0)
                        state_reg <= S_CHK;
                    else if (gu_reg[0] || gv_reg[0])
                        state_reg <= S_GLOOP;
                S_GLOOP:
                    if (gv_reg == '0)
                        state_reg <= S_DIVN;
                S_DIVN:
                    if (bit_reg == C'(M - 1))
                        state_reg <= S_DIVD;
                S_DIVD:
                    if (bit_reg == C'(M - 1))
                        state_reg <= S_CHK;
                S_CHK:    state_reg <= S_OUT;
                S_OUT:
                    if (!full_reg || pop)
                        state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                act_reg <= q_item.action;
                ma_reg <= xa; mb_reg <= xb; mc_reg <= xc; md_reg <= xd;
                sa_reg <= q_item.num_a[W-1]; sb_reg <= q_item.den_a[W-1];
                sc_reg <= q_item.num_b[W-1]; sd_reg <= q_item.den_b[W-1];
                same_reg <= (q_item.den_a[W-1:0] == q_item.den_b[W-1:0]);
            end
            S_MUL1:
            begin
                p1_reg <= mul_x;
                s1_reg <= (act_reg == rfa_pkg::ACT_DIV) ? (sb_reg ^ sc_reg)
                                                         : (sb_reg ^ sd_reg);
            end
            S_MUL2:
            begin
                if (is_addsub && same_reg)
                begin
                    dm_reg   <= M'(mb_reg);
                    dneg_reg <= sb_reg;
                    p0_reg   <= M'(ma_reg);
                    s0_reg   <= sa_reg;
                end
                else
                begin
                    dm_reg   <= p1_reg;
                    dneg_reg <= s1_reg;
                    p0_reg   <= mul_x;
                    s0_reg   <= (act_reg == rfa_pkg::ACT_MUL) ? (sa_reg ^ sc_reg)
                                                               : (sa_reg ^ sd_reg);
                end
            end
            S_MUL3:
            begin
                if (is_addsub)
                begin
                    p1_reg <= same_reg ? M'(mc_reg) : mul_x;
                    s1_reg <= same_reg ? sc_reg : (sc_reg ^ sb_reg);
                end
            end
            S_FORM:
            begin
                if (is_addsub)
                begin
                    nm_reg   <= sum_n;
                    nneg_reg <= sum_neg;
                    gu_reg   <= sum_n[M-1:0];
                end
                else
                begin
                    nm_reg   <= {1'b0, p0_reg};
                    nneg_reg <= s0_reg;
                    gu_reg   <= p0_reg;
                end
                gv_reg <= dm_reg;
                sh_reg <= '0;
            end
            S_GSTRIP:
            begin
                if (dm_reg != '0 && nm_reg != '0 && !gu_reg[0] && !gv_reg[0])
                begin
                    gu_reg <= gu_reg >> 1;
                    gv_reg <= gv_reg >> 1;
                    sh_reg <= sh_reg + C'(1);
                end
            end
            S_GLOOP:
            begin
                if (gv_reg == '0)
                begin
                    g_reg   <= gu_reg << sh_reg;
                    qn_reg  <= nm_reg[M-1:0];
                    rem_reg <= '0;
                    bit_reg <= '0;
                end
                else if (!gu_reg[0])
                    gu_reg <= gu_reg >> 1;
                else if (!gv_reg[0])
                    gv_reg <= gv_reg >> 1;
                else if (gu_reg > gv_reg)
                    gu_reg <= (gu_reg - gv_reg) >> 1;
                else
                    gv_reg <= (gv_reg - gu_reg) >> 1;
            end
            S_DIVN, S_DIVD:
            begin
                if (bit_reg == C'(M - 1))
                begin
                    bit_reg <= '0;
                    rem_reg <= '0;
                    if (state_reg == S_DIVN)
                    begin
                        quo_reg <= {qn_reg[M-2:0], !rem_try[M]};
                        qn_reg  <= dm_reg;
                    end
                    else
                        qn_reg <= {qn_reg[M-2:0], !rem_try[M]};
                end
                else
                begin
                    rem_reg <= rem_try[M] ? rem_sh : rem_try[M-1:0];
                    qn_reg  <= {qn_reg[M-2:0], !rem_try[M]};
                    bit_reg <= bit_reg + C'(1);
                end
            end
            S_CHK:
            begin
                if (dm_reg == '0)
                    fin_reg <= '{res_num: '0, res_den: '0, status: rfa_pkg::ST_ZDEN};
                else if (nm_reg == '0)
                    fin_reg <= '{res_num: '0, res_den: 32'd1, status: rfa_pkg::ST_OK};
                else if ((nneg_reg ? (quo_reg > half) : (quo_reg >= half)) ||
                         (dneg_reg ? (qn_reg > half) : (qn_reg >= half)))
                    fin_reg <= '{res_num: '0, res_den: '0, status: rfa_pkg::ST_OVF};
                else
                begin
                    fin_reg.res_num <= nneg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
                    fin_reg.res_den <= dneg_reg ? (32'd0 - qn_reg[31:0]) : qn_reg[31:0];
                    fin_reg.status  <= rfa_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational fraction ALU testbench
// Pushes fraction pairs with every action through the queue ports, predicts
// the reduced quotient and status per word, and checks each popped word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WatchdogLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  action;
    logic signed [31:0] num_a;
    logic signed [31:0] den_a;
    logic signed [31:0] num_b;
    logic signed [31:0] den_b;
    logic        empty;
    logic        pop;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]  status;

    rfa_pkg::item_t   pending_q[$];
    rfa_pkg::result_t quotient_q[$];
    int      mismatch_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cycles;
    int      idle_cycles;
    bit      stim_done;

    rational_fraction_alu_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .action  (action),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b),
        .empty   (empty),
        .pop     (pop),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // signed values held exactly in 128 bits; nothing wraps
    function automatic rfa_pkg::result_t reduce_fraction(rfa_pkg::item_t it);
        rfa_pkg::result_t r;
        logic signed [127:0] na, da, nb, db, n, d;
        logic [63:0] nm, dm, g;
        na = 128'(signed'(it.num_a));
        da = 128'(signed'(it.den_a));
        nb = 128'(signed'(it.num_b));
        db = 128'(signed'(it.den_b));
        case (rfa_pkg::action_t'(it.action))
            rfa_pkg::ACT_ADD, rfa_pkg::ACT_SUB:
            begin
                if (it.action == rfa_pkg::ACT_SUB)
                    nb = -nb;
                if (da == db)
                begin
                    n = na + nb;
                    d = da;
                end
                else
                begin
                    n = na * db + nb * da;
                    d = da * db;
                end
            end
            rfa_pkg::ACT_MUL:
            begin
                n = na * nb;
                d = da * db;
            end
            default:
            begin
                n = na * db;
                d = da * nb;
            end
        endcase
        r = '0;
        if (d == 0)
            r.status = rfa_pkg::ST_ZDEN;
        else if (n == 0)
        begin
            r.res_den = 32'd1;
            r.status  = rfa_pkg::ST_OK;
        end
        else
        begin
            nm = (n < 0) ? 64'(-n) : 64'(n);
            dm = (d < 0) ? 64'(-d) : 64'(d);
            g  = gcd64(nm, dm);
            n  = (n < 0) ? -128'(nm / g) : 128'(nm / g);
            d  = (d < 0) ? -128'(dm / g) : 128'(dm / g);
            if (n > 128'sd2147483647 || n < -128'sd2147483648 ||
                d > 128'sd2147483647 || d < -128'sd2147483648)
                r.status = rfa_pkg::ST_OVF;
            else
            begin
                r.res_num = n[31:0];
                r.res_den = d[31:0];
                r.status  = rfa_pkg::ST_OK;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4, 5: return $urandom;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || quotient_q.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push   <= 1'b0;
            action <= '0;
            num_a  <= '0;
            den_a  <= '0;
            num_b  <= '0;
            den_b  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                quotient_q.push_back(reduce_fraction(pending_q.pop_front()));
                if (pending_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    push   <= 1'b1;
                    action <= pending_q[0].action;
                    num_a  <= pending_q[0].num_a;
                    den_a  <= pending_q[0].den_a;
                    num_b  <= pending_q[0].num_b;
                    den_b  <= pending_q[0].den_b;
                end
                else
                    push <= 1'b0;
            end
            else if (!push && pending_q.size() != 0 &&
                     $urandom_range(1, 100) > send_idle_pct)
            begin
                push   <= 1'b1;
                action <= pending_q[0].action;
                num_a  <= pending_q[0].num_a;
                den_a  <= pending_q[0].den_a;
                num_b  <= pending_q[0].num_b;
                den_b  <= pending_q[0].den_b;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rfa_pkg::result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (quotient_q.size() == 0)
                begin
                    $display("unexpected word at %0t", $realtime);
                    mismatch_cnt++;
                end
                else
                begin
                    want = quotient_q.pop_front();
                    if (res_num !== want.res_num)
                        report_mismatch("res_num", res_num, want.res_num);
                    if (res_den !== want.res_den)
                        report_mismatch("res_den", res_den, want.res_den);
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) ||
            (stim_done && quotient_q.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rfa_pkg::item_t it;
        logic [31:0] ops[8];
        mismatch_cnt    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        idle_cycles     = 0;
        stim_done       = 1'b0;
        rst_n           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        action          = '0;
        num_a           = '0;
        den_a           = '0;
        num_b           = '0;
        den_b           = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero denominators, zero numerators, overflow
        ops = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff,
                32'd6, 32'hffff_fffc, 32'd9};
        for (int k = 0; k < 24; k++)
        begin
            it.action = rfa_pkg::action_t'(k % 4);
            it.num_a  = ops[k % 8];
            it.den_a  = ops[(k + 1 + k / 8) % 8];
            it.num_b  = ops[(k + 3) % 8];
            it.den_b  = (k % 5 == 0) ? it.den_a : ops[(k + 5 + k / 4) % 8];
            pending_q.push_back(it);
        end
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (phase == 4)
                hold_off_cycles = 3000;
            for (int k = 0; k < 320; k++)
            begin
                it.action = 2'($urandom_range(0, 3));
                it.num_a  = pick_operand();
                it.den_a  = pick_operand();
                it.num_b  = pick_operand();
                it.den_b  = ($urandom_range(0, 3) == 0) ? it.den_a : pick_operand();
                pending_q.push_back(it);
            end
            wait_drained();
        end
        stim_done = 1'b1;
        repeat (500) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
